// File: sv/ald_pkg.sv
// types, constants and register codes shared by the anchor landmark decoder
`timescale 1ns / 1ps

package ald_pkg;

    localparam int MAX_MAP_WIDTH = 4096;
    localparam int POS_W         = 12;
    localparam int MAP_W_W       = 13;
    localparam int SUM_W         = 17;
    localparam int PROD_W        = 30;
    localparam int BASE_W        = 20;
    localparam int ACC_W         = 34;
    localparam int COORD_W       = 24;
    localparam int ROUND_SHIFT   = 8;
    localparam int ROUND_HALF    = 128;
    localparam int FRAC_SHIFT    = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_STRIDE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_BIAS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH       = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic               map_start;
        logic signed [15:0] score;
        logic               mask_on;
        logic [7:0]         class_label;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic               cell_end;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [15:0]        det_score;
        logic [7:0]                det_label;
        logic                      point_last;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0]  score_threshold;
        logic [6:0]          cell_stride;
        logic [11:0]         center_bias;
        logic [11:0]         box_width;
        logic [11:0]         box_height;
        logic [MAP_W_W-1:0]  map_width;
    } cfg_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic [POS_W-1:0]        column;
        logic [POS_W-1:0]        row;
        logic signed [15:0]      score;
        logic [7:0]              label;
        logic                    last;
    } queue_entry_t;

endpackage

// File: sv/ald_front.sv
// front end: accepts points, tracks cell position, filters passing cells
`timescale 1ns / 1ps

module ald_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ald_pkg::in_item_t     s_data,
    input  ald_pkg::cfg_t         cfg,
    input  logic                  queue_full,
    output logic                  push_valid,
    output ald_pkg::queue_entry_t push_data
);
    import ald_pkg::*;

    logic [POS_W-1:0]   column_reg, column_next;
    logic [POS_W-1:0]   row_reg, row_next;
    logic [POS_W-1:0]   column_base, row_base;
    logic [MAP_W_W-1:0] eff_width;
    logic [MAP_W_W-1:0] column_inc;
    logic               accept;
    logic               pass;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    assign column_base = s_data.map_start ? '0 : column_reg;
    assign row_base    = s_data.map_start ? '0 : row_reg;

    assign pass = (s_data.score >= cfg.score_threshold) && s_data.mask_on;

    always_comb begin
        if (cfg.map_width == '0) begin
            eff_width = MAP_W_W'(1);
        end else if (cfg.map_width > MAP_W_W'(MAX_MAP_WIDTH)) begin
            eff_width = MAP_W_W'(MAX_MAP_WIDTH);
        end else begin
            eff_width = cfg.map_width;
        end
    end

    assign column_inc = {1'b0, column_base} + MAP_W_W'(1);

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        if (accept) begin
            column_next = column_base;
            row_next    = row_base;
            if (s_data.cell_end) begin
                if (column_inc >= eff_width) begin
                    column_next = '0;
                    row_next    = row_base + POS_W'(1);
                end else begin
                    column_next = column_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign push_valid       = accept && pass;
    assign push_data.sum_x  = SUM_W'(s_data.delta_x) + SUM_W'(s_data.offset_x);
    assign push_data.sum_y  = SUM_W'(s_data.delta_y) + SUM_W'(s_data.offset_y);
    assign push_data.column = column_base;
    assign push_data.row    = row_base;
    assign push_data.score  = s_data.score;
    assign push_data.label  = s_data.class_label;
    assign push_data.last   = s_data.cell_end;

endmodule

// File: sv/ald_queue.sv
// short queue of passing points between front and back end
`timescale 1ns / 1ps

module ald_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    input  ald_pkg::queue_entry_t push_data,
    output logic                  full,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output ald_pkg::queue_entry_t pop_data
);
    import ald_pkg::*;

    queue_entry_t           mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    logic                   pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign push      = push_valid && !full;
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !full)
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + QUEUE_CNT_W'(1)))
        else $error("queue count did not follow push");

endmodule

// File: sv/ald_back.sv
// back end: scales deltas by box size, adds cell position, rounds and saturates
`timescale 1ns / 1ps

module ald_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ald_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  ald_pkg::queue_entry_t q_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ald_pkg::out_item_t    m_data
);
    import ald_pkg::*;

    logic                     s1_valid_reg, s1_valid_next;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic [BASE_W-1:0]        base_x_reg, base_y_reg;
    logic signed [15:0]       score_reg;
    logic [7:0]               label_reg;
    logic                     last_reg;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic [BASE_W-1:0]        base_x, base_y;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg;
    logic                     s2_ready;
    logic                     s1_ready;
    logic [ACC_W-1:0]         acc_x, acc_y;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [ACC_W-1:0] acc);
        logic [ACC_W-ROUND_SHIFT-1:0] q;
        logic [COORD_W-1:0]           res;
        q = acc[ACC_W-1:ROUND_SHIFT];
        if (!q[ACC_W-ROUND_SHIFT-1] && (q[ACC_W-ROUND_SHIFT-2:COORD_W-1] != '0)) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (q[ACC_W-ROUND_SHIFT-1] && (q[ACC_W-ROUND_SHIFT-2:COORD_W-1] != '1)) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = q[COORD_W-1:0];
        end
        return res;
    endfunction

    assign s2_ready = !m_valid_reg || m_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_ready  = s1_ready;

    // stage 1: box scaling and position scaling
    assign prod_x = PROD_W'(q_data.sum_x) * PROD_W'($signed({1'b0, cfg.box_width}));
    assign prod_y = PROD_W'(q_data.sum_y) * PROD_W'($signed({1'b0, cfg.box_height}));
    assign base_x = BASE_W'(q_data.column) * BASE_W'(cfg.cell_stride)
                  + BASE_W'(cfg.center_bias);
    assign base_y = BASE_W'(q_data.row) * BASE_W'(cfg.cell_stride)
                  + BASE_W'(cfg.center_bias);

    assign s1_valid_next = s1_ready ? q_valid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (s1_ready && q_valid) begin
            prod_x_reg <= prod_x;
            prod_y_reg <= prod_y;
            base_x_reg <= base_x;
            base_y_reg <= base_y;
            score_reg  <= q_data.score;
            label_reg  <= q_data.label;
            last_reg   <= q_data.last;
        end
    end

    // stage 2: sum in q.12, round to q.4, saturate
    assign acc_x = ACC_W'(prod_x_reg) + ACC_W'({base_x_reg, {FRAC_SHIFT{1'b0}}})
                 + ACC_W'(ROUND_HALF);
    assign acc_y = ACC_W'(prod_y_reg) + ACC_W'({base_y_reg, {FRAC_SHIFT{1'b0}}})
                 + ACC_W'(ROUND_HALF);

    assign m_valid_next = s2_ready ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            m_data_reg.coord_x    <= sat_coord(acc_x);
            m_data_reg.coord_y    <= sat_coord(acc_y);
            m_data_reg.det_score  <= score_reg;
            m_data_reg.det_label  <= label_reg;
            m_data_reg.point_last <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg)
        else $error("stage 1 point dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> s1_valid_reg)
        else $error("queue transfer not captured");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s2_ready) |=> m_valid_reg)
        else $error("stage 1 point not moved to output");

endmodule

// File: sv/anchor_landmark_decode.sv
// top level of the anchor landmark decoder: register file and front, queue, back
`timescale 1ns / 1ps

// Takes one landmark point per clock while s_ready is high and gives at most
// one decoded point per clock. Passing points leave the block through the
// queue, the stage 1 registers and the output register; failing points leave
// nothing but still advance the cell position. A four-entry queue between the
// front end and the two-stage arithmetic back end sets how far the output may
// stall before s_ready drops. Registers are written through the cfg channel,
// which is always ready; write them only while no point is in flight.
module anchor_landmark_decode (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ald_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ald_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ald_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ald_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ald_pkg::*;

    cfg_t         cfg_reg, cfg_next;
    logic         push_valid;
    queue_entry_t push_data;
    logic         queue_full;
    logic         pop_valid;
    logic         pop_ready;
    queue_entry_t pop_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SCORE_THRESHOLD: cfg_next.score_threshold = $signed(cfg_data);
                REG_CELL_STRIDE:     cfg_next.cell_stride     = cfg_data[6:0];
                REG_CENTER_BIAS:     cfg_next.center_bias     = cfg_data[11:0];
                REG_BOX_WIDTH:       cfg_next.box_width       = cfg_data[11:0];
                REG_BOX_HEIGHT:      cfg_next.box_height      = cfg_data[11:0];
                REG_MAP_WIDTH:       cfg_next.map_width       = cfg_data[MAP_W_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.score_threshold <= '0;
            cfg_reg.cell_stride     <= 7'd16;
            cfg_reg.center_bias     <= '0;
            cfg_reg.box_width       <= 12'd64;
            cfg_reg.box_height      <= 12'd64;
            cfg_reg.map_width       <= 13'd64;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ald_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    ald_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ald_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_data  (pop_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
